/* sv/fsp_pkg.sv */
// Shared types and constants of the fixed slot pool allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package fsp_pkg;

  localparam int ADDR_W     = 32;
  localparam int CNT_W      = 11;
  localparam int SIZE_W     = 16;
  localparam int QUO_W      = 11;
  localparam int DVS_W      = SIZE_W + QUO_W;
  localparam int STEP_W     = 4;
  localparam int CFG_IDX_W  = 2;

  localparam logic [ADDR_W-1:0] POOL_BASE_RESET  = 32'd0;
  localparam logic [CNT_W-1:0]  SLOT_COUNT_RESET = 11'd1024;
  localparam logic [SIZE_W-1:0] SLOT_SIZE_RESET  = 16'd64;

  localparam logic FUNC_ACQUIRE = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_BASE  = 2'd0,
    CFG_SLOT_COUNT = 2'd1,
    CFG_SLOT_SIZE  = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_RANGE    = 3'd2,
    ST_MISALIGN = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  // Outcome that the controller hands to the datapath when an item retires.
  typedef enum logic [2:0] {
    RES_ACQ_OK,
    RES_EMPTY,
    RES_RANGE,
    RES_MISALIGN,
    RES_FULL,
    RES_REL_OK
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_ACQ_ADD,
    S_DIV,
    S_REL_END
  } state_t;

  typedef struct packed {
    logic                func;
    logic [ADDR_W-1:0]   release_address;
  } req_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   slot_address;
    logic [2:0]          status;
    logic [CNT_W-1:0]    free_count;
  } rsp_item_t;

  typedef struct packed {
    logic capture;
    logic acq_mul;
    logic div_step;
    logic finish;
    res_t res;
  } dp_cmd_t;

  typedef struct packed {
    logic func_rel;
    logic top_zero;
    logic out_of_range;
    logic div_last;
    logic rem_zero;
    logic stack_full;
  } dp_status_t;

endpackage

`default_nettype wire

/* sv/fixed_slot_pool_allocator.sv */
// Top level of the fixed slot pool allocator.
// Depends on fsp_pkg, fsp_ctrl, fsp_datapath and fsp_ram.
`default_nettype none

// Fixed-size buffer pool with a LIFO stack of free slot numbers. An acquire
// pops a slot and answers pool_base + slot * slot_size; a release checks range
// and slot alignment, then pushes the slot back. Items are handled one at a
// time: an acquire multiplies the popped slot by slot_size in its decode
// state and loads its result in the add state; a release runs the
// shift-subtract divider that yields the slot number and the alignment
// remainder, one quotient bit per cycle, and then loads its result. An
// empty acquire or an out-of-range release is answered from the decode
// state. A result that is still waiting holds the item in its last state.
// The result sits in an output register, so the next request is taken while
// it waits. Writing slot_count refills the stack at once, with no clearing
// pass: a low-water mark of the stack top tells which entries still hold
// their own position. Configuration is always ready and must only be written
// while the block is idle.
module fixed_slot_pool_allocator
  import fsp_pkg::*;
#(
  parameter int MAX_SLOTS = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output logic                      req_ready,
  input  wire req_item_t            req,
  output logic                      rsp_valid,
  input  wire logic                 rsp_ready,
  output rsp_item_t                 rsp,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ADDR_W-1:0]    cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  fsp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .status    (status),
    .cmd       (cmd)
  );

  fsp_datapath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .cmd       (cmd),
    .status    (status),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

/* sv/fsp_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; no package needed.
`default_nettype none

module fsp_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* sv/fsp_ctrl.sv */
// Sequencing state machine of the slot pool: handshakes and datapath commands.
// Depends on fsp_pkg for the state, command and status types.
`default_nettype none

module fsp_ctrl
  import fsp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_ready,
  output logic            rsp_valid,
  input  wire logic       rsp_ready,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  state_t state, state_next;
  logic   out_free;

  // The result register may be loaded when empty or when its transfer happens now.
  assign out_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next   = state;
    req_ready    = 1'b0;
    cmd.capture  = 1'b0;
    cmd.acq_mul  = 1'b0;
    cmd.div_step = 1'b0;
    cmd.finish   = 1'b0;
    cmd.res      = RES_ACQ_OK;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!status.func_rel) begin
          if (status.top_zero) begin
            if (out_free) begin
              cmd.finish = 1'b1;
              cmd.res    = RES_EMPTY;
              state_next = S_IDLE;
            end
          end else begin
            cmd.acq_mul = 1'b1;
            state_next  = S_ACQ_ADD;
          end
        end else if (status.out_of_range) begin
          if (out_free) begin
            cmd.finish = 1'b1;
            cmd.res    = RES_RANGE;
            state_next = S_IDLE;
          end
        end else begin
          state_next = S_DIV;
        end
      end
      S_ACQ_ADD: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          cmd.res    = RES_ACQ_OK;
          state_next = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_REL_END;
        end
      end
      S_REL_END: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          priority if (!status.rem_zero) begin
            cmd.res = RES_MISALIGN;
          end else if (status.stack_full) begin
            cmd.res = RES_FULL;
          end else begin
            cmd.res = RES_REL_OK;
          end
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/fsp_datapath.sv */
// Datapath of the slot pool: configuration registers, free stack, stack top,
// shift-subtract divider and result register. Depends on fsp_pkg and fsp_ram.
`default_nettype none

module fsp_datapath
  import fsp_pkg::*;
#(
  parameter int MAX_SLOTS = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ADDR_W-1:0]    cfg_data,
  input  wire req_item_t            req,
  input  wire dp_cmd_t              cmd,
  output dp_status_t                status,
  output rsp_item_t                 rsp
);

  localparam int AW = $clog2(MAX_SLOTS);
  localparam int MW = $clog2(MAX_SLOTS + 1);
  localparam int CW = (MW > CNT_W) ? MW : CNT_W;

  // A slot count of zero means one; counts above the pool depth saturate.
  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v);
    logic [CW-1:0] wide;
    wide = CW'(v);
    if (v == '0) begin
      return CNT_W'(1);
    end else if (wide > CW'(MAX_SLOTS)) begin
      return CNT_W'(MAX_SLOTS);
    end
    return v;
  endfunction

  logic [ADDR_W-1:0]       pool_base;
  logic [CNT_W-1:0]        slot_count;
  logic [SIZE_W-1:0]       slot_size;
  logic [CNT_W-1:0]        top;
  logic [CNT_W-1:0]        low_mark;
  logic                    func;
  logic [CNT_W+SIZE_W-1:0] span;
  logic [ADDR_W-1:0]       rem;
  logic [DVS_W-1:0]        dvs;
  logic [QUO_W-1:0]        quo;
  logic [STEP_W-1:0]       step;
  logic [AW+SIZE_W-1:0]    prod;
  logic [CNT_W-1:0]        pos;
  logic [AW-1:0]           slot;
  logic [AW-1:0]           rd_data;
  logic                    wr_en;
  logic [ADDR_W-1:0]       offset;
  logic [SIZE_W-1:0]       size_in;

  assign pos     = top - CNT_W'(1);
  assign offset  = req.release_address - pool_base;
  assign size_in = (cfg_data[SIZE_W-1:0] == '0) ? SIZE_W'(1) : cfg_data[SIZE_W-1:0];

  // Stack entries below the lowest top seen since the last refill were never
  // overwritten and still hold their own position; entries at or above it
  // were rewritten by a push after the top dropped there.
  assign slot  = (pos >= low_mark) ? rd_data : AW'(pos);
  assign wr_en = cmd.finish && (cmd.res == RES_REL_OK);

  fsp_ram #(
    .WIDTH (AW),
    .DEPTH (MAX_SLOTS)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(top)),
    .wr_data (AW'(quo)),
    .rd_addr (AW'(pos)),
    .rd_data (rd_data)
  );

  assign status.func_rel     = (func == FUNC_RELEASE);
  assign status.top_zero     = (top == '0);
  assign status.out_of_range = (rem >= ADDR_W'(span));
  assign status.div_last     = (step == '0);
  assign status.rem_zero     = (rem == '0);
  assign status.stack_full   = (top >= slot_count);

  // Configuration and stack bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base  <= POOL_BASE_RESET;
      slot_count <= clamp_count(SLOT_COUNT_RESET);
      slot_size  <= SLOT_SIZE_RESET;
      top        <= clamp_count(SLOT_COUNT_RESET);
      low_mark   <= clamp_count(SLOT_COUNT_RESET);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_POOL_BASE: begin
          pool_base <= cfg_data;
        end
        CFG_SLOT_COUNT: begin
          slot_count <= clamp_count(cfg_data[CNT_W-1:0]);
          top        <= clamp_count(cfg_data[CNT_W-1:0]);
          low_mark   <= clamp_count(cfg_data[CNT_W-1:0]);
        end
        CFG_SLOT_SIZE: begin
          slot_size <= size_in;
        end
        default: begin
        end
      endcase
    end else if (cmd.finish) begin
      if (cmd.res == RES_ACQ_OK) begin
        top <= pos;
        if (pos < low_mark) begin
          low_mark <= pos;
        end
      end else if (cmd.res == RES_REL_OK) begin
        top <= top + CNT_W'(1);
      end
    end
  end

  // Working registers of one item and the result register.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func <= req.func;
      span <= slot_count * slot_size;
      rem  <= offset;
      dvs  <= DVS_W'(slot_size) << (QUO_W - 1);
      quo  <= '0;
      step <= STEP_W'(QUO_W - 1);
    end else if (cmd.div_step) begin
      if (rem >= ADDR_W'(dvs)) begin
        rem <= rem - ADDR_W'(dvs);
        quo <= {quo[QUO_W-2:0], 1'b1};
      end else begin
        quo <= {quo[QUO_W-2:0], 1'b0};
      end
      dvs  <= dvs >> 1;
      step <= step - STEP_W'(1);
    end
    if (cmd.acq_mul) begin
      prod <= slot * slot_size;
    end
    if (cmd.finish) begin
      unique case (cmd.res)
        RES_ACQ_OK: begin
          rsp.slot_address <= pool_base + ADDR_W'(prod);
          rsp.status       <= ST_OK;
          rsp.free_count   <= pos;
        end
        RES_EMPTY: begin
          rsp.slot_address <= '0;
          rsp.status       <= ST_EMPTY;
          rsp.free_count   <= top;
        end
        RES_RANGE: begin
          rsp.slot_address <= '0;
          rsp.status       <= ST_RANGE;
          rsp.free_count   <= top;
        end
        RES_MISALIGN: begin
          rsp.slot_address <= '0;
          rsp.status       <= ST_MISALIGN;
          rsp.free_count   <= top;
        end
        RES_FULL: begin
          rsp.slot_address <= '0;
          rsp.status       <= ST_FULL;
          rsp.free_count   <= top;
        end
        RES_REL_OK: begin
          rsp.slot_address <= '0;
          rsp.status       <= ST_OK;
          rsp.free_count   <= top + CNT_W'(1);
        end
        default: begin
          rsp.slot_address <= '0;
          rsp.status       <= ST_OK;
          rsp.free_count   <= top;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
